### rtl/core/svb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svb_pkg
// shared types and constants of the skinned vertex blend unit
// ----------------------------------------------------------------------------
package svb_pkg;

  localparam int NUM_BONES   = 64;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC = 15;

  localparam int SLOT_W    = 7;
  localparam int ELEM_W    = 4;
  localparam int DATA_W    = 32;
  localparam int WEIGHT_W  = 16;
  localparam int ACC_W     = 48;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int R_W       = PROD_W - FRAC_BITS + 3;
  localparam int DIV_SH    = 31 - FRAC_BITS;
  localparam int DIV_STEPS = 31;

  localparam int SLOT_BASE = NUM_BONES;
  localparam int SLOT_INV  = NUM_BONES + 1;
  localparam int MEM_DEPTH = (SLOT_INV + 1) * 16;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int MAC_LAST = 16 + 1;
  localparam int WT_LAST  = 3;
  localparam int CNT_W    = 5;

  localparam logic [1:0] STEP_BASE = 2'd0;
  localparam logic [1:0] STEP_BONE = 2'd1;
  localparam logic [1:0] STEP_INV  = 2'd2;

  localparam logic FUNC_LOAD      = 1'b0;
  localparam logic FUNC_INFLUENCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_WEIGHT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              capture;
    logic              mem_we;
    logic              rd_en;
    logic [ELEM_W-1:0] rd_elem;
    logic [1:0]        step;
    logic              div_init;
    logic              div_step;
    logic              div_fin;
    logic              wt_en;
    logic [1:0]        wt_idx;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic bone_ok;
    logic last;
    logic w_zero;
  } status_t;

endpackage

### rtl/core/svb_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svb_controller
// sequencer: matrix loads, matrix steps, divides, weighting and result emission
// ----------------------------------------------------------------------------
module svb_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             func_i,
  input  svb_pkg::status_t status_i,
  output svb_pkg::cmd_t    cmd_o,
  output logic             busy
);

  svb_pkg::state_e              state_q, state_d;
  logic [svb_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [1:0]                   step_q, step_d;
  logic                         accept;

  assign busy   = (state_q != svb_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svb_pkg::ST_IDLE;
      cnt_q   <= '0;
      step_q  <= svb_pkg::STEP_BASE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    logic step_done;
    state_d   = state_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    step_done = 1'b0;
    case (state_q)
      svb_pkg::ST_IDLE: begin
        if (accept && func_i == svb_pkg::FUNC_INFLUENCE) begin
          cnt_d   = '0;
          step_d  = svb_pkg::STEP_BASE;
          state_d = status_i.bone_ok ? svb_pkg::ST_MAC : svb_pkg::ST_FINISH;
        end
      end
      svb_pkg::ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == svb_pkg::CNT_W'(svb_pkg::MAC_LAST)) begin
          cnt_d   = '0;
          state_d = svb_pkg::ST_DIV_INIT;
        end
      end
      svb_pkg::ST_DIV_INIT: begin
        cnt_d = '0;
        if (status_i.w_zero) begin
          step_done = 1'b1;
        end else begin
          state_d = svb_pkg::ST_DIV;
        end
      end
      svb_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == svb_pkg::CNT_W'(svb_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = svb_pkg::ST_DIV_FIN;
        end
      end
      svb_pkg::ST_DIV_FIN: begin
        step_done = 1'b1;
      end
      svb_pkg::ST_WEIGHT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == svb_pkg::CNT_W'(svb_pkg::WT_LAST)) begin
          cnt_d   = '0;
          state_d = svb_pkg::ST_FINISH;
        end
      end
      svb_pkg::ST_FINISH: begin
        state_d = svb_pkg::ST_IDLE;
      end
      default: begin
        state_d = svb_pkg::ST_IDLE;
      end
    endcase
    if (step_done) begin
      cnt_d = '0;
      if (step_q == svb_pkg::STEP_INV) begin
        state_d = svb_pkg::ST_WEIGHT;
      end else begin
        step_d  = step_q + 1'b1;
        state_d = svb_pkg::ST_MAC;
      end
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = step_q;
    case (state_q)
      svb_pkg::ST_IDLE: begin
        cmd_o.capture = accept && func_i == svb_pkg::FUNC_INFLUENCE;
        cmd_o.mem_we  = accept && func_i == svb_pkg::FUNC_LOAD;
      end
      svb_pkg::ST_MAC: begin
        cmd_o.rd_en   = (cnt_q < svb_pkg::CNT_W'(16));
        cmd_o.rd_elem = cnt_q[svb_pkg::ELEM_W-1:0];
      end
      svb_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
      end
      svb_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      svb_pkg::ST_DIV_FIN: begin
        cmd_o.div_fin = 1'b1;
      end
      svb_pkg::ST_WEIGHT: begin
        cmd_o.wt_en  = (cnt_q < svb_pkg::CNT_W'(svb_pkg::WT_LAST));
        cmd_o.wt_idx = cnt_q[1:0];
      end
      svb_pkg::ST_FINISH: begin
        cmd_o.emit = status_i.last;
      end
      default: begin
        cmd_o.step = step_q;
      end
    endcase
  end

endmodule

### rtl/core/svb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svb_datapath
// matrix store, shared multiplier, row accumulators, divider lanes, blend
// ----------------------------------------------------------------------------
module svb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svb_pkg::cmd_t                       cmd_i,
  output svb_pkg::status_t                    status_o,
  input  logic [svb_pkg::SLOT_W-1:0]          matrix_slot_i,
  input  logic [svb_pkg::ELEM_W-1:0]          matrix_element_i,
  input  logic signed [svb_pkg::DATA_W-1:0]   matrix_value_i,
  input  logic signed [svb_pkg::DATA_W-1:0]   vert_x_i,
  input  logic signed [svb_pkg::DATA_W-1:0]   vert_y_i,
  input  logic signed [svb_pkg::DATA_W-1:0]   vert_z_i,
  input  logic signed [svb_pkg::SLOT_W-1:0]   influence_bone_i,
  input  logic [svb_pkg::WEIGHT_W-1:0]        influence_weight_i,
  input  logic                                last_influence_i,
  output logic                                valid_o,
  output logic signed [svb_pkg::DATA_W-1:0]   skinned_x_o,
  output logic signed [svb_pkg::DATA_W-1:0]   skinned_y_o,
  output logic signed [svb_pkg::DATA_W-1:0]   skinned_z_o,
  output logic                                zero_w_seen_o
);

  localparam int RW  = svb_pkg::R_W;
  localparam int DW  = svb_pkg::DATA_W;
  localparam int SH  = svb_pkg::DIV_SH;
  localparam int QW  = svb_pkg::DIV_STEPS;
  localparam int AW  = svb_pkg::ACC_W;

  logic [DW-1:0]                    mem [svb_pkg::MEM_DEPTH];

  logic signed [DW-1:0]             vec_q [3];
  logic [svb_pkg::SLOT_W-1:0]       bone_q;
  logic [svb_pkg::WEIGHT_W-1:0]     weight_q;
  logic                             last_q;

  logic signed [DW-1:0]             rdata_q;
  logic                             rv_q;
  logic [svb_pkg::ELEM_W-1:0]       re_q;

  logic signed [svb_pkg::PROD_W-1:0] prod_q;
  logic                             pv_q, pw_q;
  logic [svb_pkg::ELEM_W-1:0]       pe_q;

  logic signed [RW-1:0]             r_q [4];
  logic signed [AW-1:0]             acc_q [3];
  logic                             sticky_q;

  logic [RW-1:0]                    ud_q;
  logic [RW-1:0]                    rem_q [3];
  logic [QW-1:0]                    quo_q [3];
  logic [QW-1:0]                    dsh_q [3];
  logic                             sat_q [3];
  logic                             neg_q [3];

  logic                             valid_q;
  logic signed [DW-1:0]             out_q [3];
  logic                             zw_q;

  logic [svb_pkg::SLOT_W-1:0]       rd_slot;
  logic [svb_pkg::ADDR_W-1:0]       rd_addr, wr_addr;
  logic signed [DW-1:0]             mul_a, mul_b;
  logic signed [RW-1:0]             term;
  logic [RW-1:0]                    ud_now;
  logic [RW-1:0]                    un_now [3];

  assign status_o.bone_ok = !influence_bone_i[svb_pkg::SLOT_W-1]
                            && ($unsigned(influence_bone_i)
                                < svb_pkg::SLOT_W'(svb_pkg::NUM_BONES));
  assign status_o.last    = last_q;
  assign status_o.w_zero  = (r_q[3] == '0);

  // matrix store
  assign wr_addr = svb_pkg::ADDR_W'({matrix_slot_i, matrix_element_i});

  always_comb begin
    case (cmd_i.step)
      svb_pkg::STEP_BASE: rd_slot = svb_pkg::SLOT_W'(svb_pkg::SLOT_BASE);
      svb_pkg::STEP_BONE: rd_slot = bone_q;
      default:            rd_slot = svb_pkg::SLOT_W'(svb_pkg::SLOT_INV);
    endcase
  end
  assign rd_addr = svb_pkg::ADDR_W'({rd_slot, cmd_i.rd_elem});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && matrix_slot_i <= svb_pkg::SLOT_W'(svb_pkg::SLOT_INV)) begin
      mem[wr_addr] <= matrix_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    re_q    <= cmd_i.rd_elem;
  end

  // shared multiplier
  always_comb begin
    mul_a = vec_q[0];
    mul_b = rdata_q;
    if (rv_q) begin
      case (re_q[3:2])
        2'd0:    mul_a = vec_q[0];
        2'd1:    mul_a = vec_q[1];
        2'd2:    mul_a = vec_q[2];
        default: mul_a = DW'(1) <<< svb_pkg::FRAC_BITS;
      endcase
    end else begin
      case (cmd_i.wt_idx)
        2'd0:    mul_a = vec_q[0];
        2'd1:    mul_a = vec_q[1];
        default: mul_a = vec_q[2];
      endcase
      mul_b = $signed(DW'(weight_q));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    pe_q   <= cmd_i.wt_en ? svb_pkg::ELEM_W'(cmd_i.wt_idx) : re_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      pv_q <= 1'b0;
      pw_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.rd_en;
      pv_q <= rv_q || cmd_i.wt_en;
      pw_q <= cmd_i.wt_en;
    end
  end

  // row sums
  assign term = RW'(prod_q >>> svb_pkg::FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (pv_q && !pw_q) begin
      for (int k = 0; k < 4; k++) begin
        if (pe_q[1:0] == 2'(k)) begin
          r_q[k] <= (pe_q[3:2] == 2'd0) ? term : r_q[k] + term;
        end
      end
    end
  end

  // divider lanes
  assign ud_now = r_q[3][RW-1] ? RW'(-r_q[3]) : RW'(r_q[3]);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      un_now[i] = r_q[i][RW-1] ? RW'(-r_q[i]) : RW'(r_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [RW:0] trial;
    if (cmd_i.div_init) begin
      ud_q <= ud_now;
    end
    for (int i = 0; i < 3; i++) begin
      trial = {rem_q[i], dsh_q[i][QW-1]};
      if (cmd_i.div_init) begin
        sat_q[i] <= ((RW+SH)'(un_now[i]) >= ((RW+SH)'(ud_now) << SH));
        rem_q[i] <= RW'(un_now[i] >> SH);
        dsh_q[i] <= {un_now[i][SH-1:0], svb_pkg::FRAC_BITS'(0)};
        neg_q[i] <= r_q[i][RW-1] ^ r_q[3][RW-1];
        quo_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        dsh_q[i] <= dsh_q[i] << 1;
        if (trial >= {1'b0, ud_q}) begin
          rem_q[i] <= RW'(trial - {1'b0, ud_q});
          quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
        end else begin
          rem_q[i] <= RW'(trial);
          quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // vertex register and influence fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vec_q[0] <= vert_x_i;
      vec_q[1] <= vert_y_i;
      vec_q[2] <= vert_z_i;
      bone_q   <= influence_bone_i;
      weight_q <= influence_weight_i;
      last_q   <= last_influence_i;
    end else if (cmd_i.div_init && status_o.w_zero) begin
      for (int i = 0; i < 3; i++) begin
        vec_q[i] <= '0;
      end
    end else if (cmd_i.div_fin) begin
      for (int i = 0; i < 3; i++) begin
        if (sat_q[i]) begin
          vec_q[i] <= neg_q[i] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
          vec_q[i] <= neg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
        end
      end
    end
  end

  // blend accumulators and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [AW+1:0] wsum;
    logic [AW-DW:0]       hi;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
      sticky_q <= 1'b0;
      valid_q  <= 1'b0;
      zw_q     <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.emit) begin
        zw_q     <= sticky_q;
        sticky_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= '0;
        end
      end else begin
        if (cmd_i.div_init && status_o.w_zero) begin
          sticky_q <= 1'b1;
        end
        if (pv_q && pw_q) begin
          for (int i = 0; i < 3; i++) begin
            wsum = (AW+2)'(acc_q[i]) + (AW+2)'(prod_q >>> svb_pkg::WEIGHT_FRAC);
            hi   = wsum[AW+1:AW-1] == 3'b000 || wsum[AW+1:AW-1] == 3'b111 ? '0 : '1;
            if (pe_q[1:0] == 2'(i)) begin
              if (hi == '0) begin
                acc_q[i] <= AW'(wsum);
              end else begin
                acc_q[i] <= wsum[AW+1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [AW-DW:0] top;
    if (cmd_i.emit) begin
      for (int i = 0; i < 3; i++) begin
        top = acc_q[i][AW-1:DW-1];
        if ((&top) || !(|top)) begin
          out_q[i] <= DW'(acc_q[i]);
        end else begin
          out_q[i] <= acc_q[i][AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
      end
    end
  end

  assign valid_o       = valid_q;
  assign skinned_x_o   = out_q[0];
  assign skinned_y_o   = out_q[1];
  assign skinned_z_o   = out_q[2];
  assign zero_w_seen_o = zw_q;

endmodule

### rtl/core/skinned_vertex_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skinned_vertex_blend_unit
// linear blend skinning of one vertex over its bone influences, fixed point
// ----------------------------------------------------------------------------
// matrix element load: written when start is accepted, busy stays low
// influence with a valid bone: three matrix steps (base, bone, inverse), each a pass
//   through the shared multiplier followed by the 31-step divider, then weighting;
//   a step that meets w equal to zero skips its divide; a skipped bone goes straight to finish
// result strobe comes the cycle after the last busy cycle; the receiver cannot stall
// reset clears state machine, accumulators and sticky flag; matrix store is not cleared
module skinned_vertex_blend_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [svb_pkg::SLOT_W-1:0]        matrix_slot_i,
  input  logic [svb_pkg::ELEM_W-1:0]        matrix_element_i,
  input  logic signed [svb_pkg::DATA_W-1:0] matrix_value_i,
  input  logic signed [svb_pkg::DATA_W-1:0] vert_x_i,
  input  logic signed [svb_pkg::DATA_W-1:0] vert_y_i,
  input  logic signed [svb_pkg::DATA_W-1:0] vert_z_i,
  input  logic signed [svb_pkg::SLOT_W-1:0] influence_bone_i,
  input  logic [svb_pkg::WEIGHT_W-1:0]      influence_weight_i,
  input  logic                              last_influence_i,
  output logic                              valid_o,
  output logic signed [svb_pkg::DATA_W-1:0] skinned_x_o,
  output logic signed [svb_pkg::DATA_W-1:0] skinned_y_o,
  output logic signed [svb_pkg::DATA_W-1:0] skinned_z_o,
  output logic                              zero_w_seen_o
);

  svb_pkg::cmd_t    cmd;
  svb_pkg::status_t status;

  svb_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  svb_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .matrix_slot_i      (matrix_slot_i),
    .matrix_element_i   (matrix_element_i),
    .matrix_value_i     (matrix_value_i),
    .vert_x_i           (vert_x_i),
    .vert_y_i           (vert_y_i),
    .vert_z_i           (vert_z_i),
    .influence_bone_i   (influence_bone_i),
    .influence_weight_i (influence_weight_i),
    .last_influence_i   (last_influence_i),
    .valid_o            (valid_o),
    .skinned_x_o        (skinned_x_o),
    .skinned_y_o        (skinned_y_o),
    .skinned_z_o        (skinned_z_o),
    .zero_w_seen_o      (zero_w_seen_o)
  );

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for two cycles");

  a_idle_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while busy");

  a_influence_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == svb_pkg::FUNC_INFLUENCE) |=> busy)
    else $error("influence transaction did not start work");

  a_load_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == svb_pkg::FUNC_LOAD) |=> (!busy && !valid_o))
    else $error("load transaction started work");

endmodule
